@@ rtl/core/rmq_pkg.sv @@
// Shared types and constants for the rotation matrix to quaternion pipeline.
package rmq_pkg;

    localparam int DW = 16;
    localparam int FB = 14;

    // Diagonal sums of three elements and off-diagonal sums of two.
    localparam int SUM_W = DW + 2;
    localparam int NUM_W = DW + 1;
    // The largest diagonal sum is never negative, so one bit less holds S + 1.0.
    localparam int A_W = SUM_W - 1;
    localparam int XR_SHIFT = FB - 2;

    // Root operand (S + 1.0) * 2^(FB-2), padded to an even width.
    localparam int SQ_IN_W = 30;
    localparam int ROOT_W = SQ_IN_W / 2;
    localparam int REM_W = ROOT_W + 3;
    localparam int DEN_W = ROOT_W + 2;

    // Divider: dividend is |N| * 2^FB + den/2, quotient stays below 2^Q_W.
    localparam int DVD_W = 32;
    localparam int Q_W = 17;
    localparam int DR_W = DEN_W + 1;

    typedef logic signed [DW-1:0] elem_t;

    typedef enum logic [1:0] {
        PICK_W,
        PICK_X,
        PICK_Y,
        PICK_Z
    } pick_t;

    typedef struct packed {
        elem_t r0c0;
        elem_t r0c1;
        elem_t r0c2;
        elem_t r1c0;
        elem_t r1c1;
        elem_t r1c2;
        elem_t r2c0;
        elem_t r2c1;
        elem_t r2c2;
    } mat_t;

    // The three numerators are the non-picked components in w, x, y, z order.
    typedef struct packed {
        pick_t            pick;
        logic [NUM_W-1:0] n0;
        logic [NUM_W-1:0] n1;
        logic [NUM_W-1:0] n2;
    } side_t;

    typedef struct packed {
        side_t              side;
        logic [SQ_IN_W-1:0] xr;
    } root_req_t;

    typedef struct packed {
        pick_t                 pick;
        logic [ROOT_W-1:0]     root;
        logic [DEN_W-1:0]      den;
        logic [2:0]            neg;
        logic [2:0][DVD_W-1:0] dvd;
    } div_req_t;

    typedef struct packed {
        elem_t w;
        elem_t x;
        elem_t y;
        elem_t z;
    } quat_t;

endpackage

@@ rtl/core/rmq_if.sv @@
// Stream interfaces for matrix input beats and quaternion output beats.
interface rmq_mat_if import rmq_pkg::*; ();
    logic  valid;
    logic  ready;
    elem_t m_r0c0;
    elem_t m_r0c1;
    elem_t m_r0c2;
    elem_t m_r1c0;
    elem_t m_r1c1;
    elem_t m_r1c2;
    elem_t m_r2c0;
    elem_t m_r2c1;
    elem_t m_r2c2;

    modport source (
        output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1,
               m_r2c2,
        input  ready
    );
    modport sink (
        input  valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1,
               m_r2c2,
        output ready
    );
endinterface

interface rmq_quat_if import rmq_pkg::*; ();
    logic  valid;
    logic  ready;
    elem_t quat_w;
    elem_t quat_x;
    elem_t quat_y;
    elem_t quat_z;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z,
        input  ready
    );
    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z,
        output ready
    );
endinterface

@@ rtl/core/rotation_matrix_to_quaternion_top.sv @@
// Top level of the rotation matrix to quaternion converter (Shepperd's method).
//
//  Port   Dir   Beat payload
//  -----  ----  ---------------------------------------------------
//  mat    sink  m_r0c0 .. m_r2c2, nine signed Q2.14 matrix elements
//  quat   src   quat_w, quat_x, quat_y, quat_z, signed Q2.14
//
// A beat enters every cycle unless quat stalls; it passes two stages of sums and pick,
// fifteen root stages plus one rounding stage, seventeen divider stages and the output
// register. A stall of the output freezes the whole pipeline, so mat.ready falls only
// while a finished beat waits on quat. Reset clears every stage valid bit at once.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    rmq_mat_if.sink     mat,
    rmq_quat_if.source  quat
);

    logic      adv;
    mat_t      m;
    logic      req_valid;
    root_req_t req;
    logic      dreq_valid;
    div_req_t  dreq;
    logic      res_valid;
    quat_t     res;

    assign adv       = !res_valid || quat.ready;
    assign mat.ready = adv;

    assign m = '{r0c0: mat.m_r0c0, r0c1: mat.m_r0c1, r0c2: mat.m_r0c2,
                 r1c0: mat.m_r1c0, r1c1: mat.m_r1c1, r1c2: mat.m_r1c2,
                 r2c0: mat.m_r2c0, r2c1: mat.m_r2c1, r2c2: mat.m_r2c2};

    rmq_diag u_diag (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (mat.valid),
        .m         (m),
        .req_valid (req_valid),
        .req       (req)
    );

    rmq_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .req_valid  (req_valid),
        .req        (req),
        .dreq_valid (dreq_valid),
        .dreq       (dreq)
    );

    rmq_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .dreq_valid (dreq_valid),
        .dreq       (dreq),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign quat.valid  = res_valid;
    assign quat.quat_w = res.w;
    assign quat.quat_x = res.x;
    assign quat.quat_y = res.y;
    assign quat.quat_z = res.z;

endmodule

@@ rtl/core/rmq_diag.sv @@
// Diagonal sums, largest-sum pick and numerator selection (two stages).
module rmq_diag import rmq_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_valid,
    input  mat_t      m,
    output logic      req_valid,
    output root_req_t req
);

    typedef struct packed {
        logic signed [SUM_W-1:0] s0;
        logic signed [SUM_W-1:0] s1;
        logic signed [SUM_W-1:0] s2;
        logic signed [SUM_W-1:0] s3;
        logic signed [NUM_W-1:0] d12;
        logic signed [NUM_W-1:0] s12;
        logic signed [NUM_W-1:0] d20;
        logic signed [NUM_W-1:0] s20;
        logic signed [NUM_W-1:0] d01;
        logic signed [NUM_W-1:0] s01;
    } sums_t;

    logic      a_valid_reg;
    sums_t     a_reg;
    sums_t     a_next;
    logic      b_valid_reg;
    root_req_t b_reg;
    root_req_t b_next;

    logic signed [SUM_W-1:0] best;
    pick_t                   pk;
    logic [A_W-1:0]          a_sum;

    always_comb
    begin
        a_next.s0  = SUM_W'(m.r0c0) + SUM_W'(m.r1c1) + SUM_W'(m.r2c2);
        a_next.s1  = SUM_W'(m.r0c0) - SUM_W'(m.r1c1) - SUM_W'(m.r2c2);
        a_next.s2  = SUM_W'(m.r1c1) - SUM_W'(m.r0c0) - SUM_W'(m.r2c2);
        a_next.s3  = SUM_W'(m.r2c2) - SUM_W'(m.r0c0) - SUM_W'(m.r1c1);
        a_next.d12 = NUM_W'(m.r1c2) - NUM_W'(m.r2c1);
        a_next.s12 = NUM_W'(m.r1c2) + NUM_W'(m.r2c1);
        a_next.d20 = NUM_W'(m.r2c0) - NUM_W'(m.r0c2);
        a_next.s20 = NUM_W'(m.r2c0) + NUM_W'(m.r0c2);
        a_next.d01 = NUM_W'(m.r0c1) - NUM_W'(m.r1c0);
        a_next.s01 = NUM_W'(m.r0c1) + NUM_W'(m.r1c0);
    end

    // Strict compares so that a tie stays with the earlier component.
    always_comb
    begin
        best = a_reg.s0;
        pk   = PICK_W;
        if (a_reg.s1 > best)
        begin
            best = a_reg.s1;
            pk   = PICK_X;
        end
        if (a_reg.s2 > best)
        begin
            best = a_reg.s2;
            pk   = PICK_Y;
        end
        if (a_reg.s3 > best)
        begin
            best = a_reg.s3;
            pk   = PICK_Z;
        end
        a_sum            = A_W'(best) + A_W'(1 << FB);
        b_next.xr        = SQ_IN_W'(a_sum) << XR_SHIFT;
        b_next.side.pick = pk;
        unique case (pk)
            PICK_W:
            begin
                b_next.side.n0 = a_reg.d12;
                b_next.side.n1 = a_reg.d20;
                b_next.side.n2 = a_reg.d01;
            end
            PICK_X:
            begin
                b_next.side.n0 = a_reg.d12;
                b_next.side.n1 = a_reg.s01;
                b_next.side.n2 = a_reg.s20;
            end
            PICK_Y:
            begin
                b_next.side.n0 = a_reg.d20;
                b_next.side.n1 = a_reg.s01;
                b_next.side.n2 = a_reg.s12;
            end
            default:
            begin
                b_next.side.n0 = a_reg.d01;
                b_next.side.n1 = a_reg.s20;
                b_next.side.n2 = a_reg.s12;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign req_valid = b_valid_reg;
    assign req       = b_reg;

endmodule

@@ rtl/core/rmq_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, then rounding.
module rmq_sqrt import rmq_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      req_valid,
    input  root_req_t req,
    output logic      dreq_valid,
    output div_req_t  dreq
);

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        logic [SQ_IN_W-1:0] xs;
        side_t              side;
    } sq_stage_t;

    logic      valid_reg [ROOT_W];
    sq_stage_t stage_reg [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_stage
        logic             valid_in;
        sq_stage_t        in_s;
        sq_stage_t        stage_next;
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;

        if (g == 0)
        begin : g_first
            assign valid_in  = req_valid;
            assign in_s.rem  = '0;
            assign in_s.root = '0;
            assign in_s.xs   = req.xr;
            assign in_s.side = req.side;
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[g-1];
            assign in_s     = stage_reg[g-1];
        end

        // Bring down two operand bits and try (4 * root + 1).
        always_comb
        begin
            cur             = {in_s.rem[REM_W-3:0], in_s.xs[SQ_IN_W-1 -: 2]};
            trial           = REM_W'({in_s.root, 2'b01});
            stage_next.side = in_s.side;
            stage_next.xs   = in_s.xs << 2;
            if (cur >= trial)
            begin
                stage_next.rem  = cur - trial;
                stage_next.root = {in_s.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                stage_next.rem  = cur;
                stage_next.root = {in_s.root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[g] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stage_reg[g] <= stage_next;
            end
        end
    end

    function automatic logic [DVD_W-1:0] make_dvd(input logic [NUM_W-1:0] n,
                                                  input logic [ROOT_W-1:0] r);
        logic [NUM_W-1:0] mag;
        mag = n[NUM_W-1] ? (~n + NUM_W'(1)) : n;
        return DVD_W'({mag, {FB{1'b0}}}) + DVD_W'({r, 1'b0});
    endfunction

    sq_stage_t         last;
    logic [ROOT_W-1:0] r_fin;
    logic              out_valid_reg;
    div_req_t          out_reg;
    div_req_t          out_next;

    assign last = stage_reg[ROOT_W-1];

    // Round up when the remainder exceeds the floor root.
    always_comb
    begin
        r_fin           = last.root + ROOT_W'(last.rem > REM_W'(last.root));
        out_next.pick   = last.side.pick;
        out_next.root   = r_fin;
        out_next.den    = {r_fin, 2'b00};
        out_next.neg    = {last.side.n2[NUM_W-1], last.side.n1[NUM_W-1],
                           last.side.n0[NUM_W-1]};
        out_next.dvd[0] = make_dvd(last.side.n0, r_fin);
        out_next.dvd[1] = make_dvd(last.side.n1, r_fin);
        out_next.dvd[2] = make_dvd(last.side.n2, r_fin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= valid_reg[ROOT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign dreq_valid = out_valid_reg;
    assign dreq       = out_reg;

endmodule

@@ rtl/core/rmq_div.sv @@
// Three pipelined restoring dividers sharing one divisor, then sign, saturation and placement.
module rmq_div import rmq_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     dreq_valid,
    input  div_req_t dreq,
    output logic     res_valid,
    output quat_t    res
);

    typedef struct packed {
        pick_t                pick;
        logic [ROOT_W-1:0]    root;
        logic [DEN_W-1:0]     den;
        logic [2:0]           neg;
        logic [2:0][DR_W-1:0] rem;
        logic [2:0][Q_W-1:0]  dv;
        logic [2:0][Q_W-1:0]  q;
    } dv_stage_t;

    localparam logic signed [Q_W:0] SAT_HI = (Q_W + 1)'((1 << (DW - 1)) - 1);
    localparam logic signed [Q_W:0] SAT_LO = -SAT_HI - (Q_W + 1)'(1);

    logic      valid_reg [Q_W];
    dv_stage_t stage_reg [Q_W];

    for (genvar g = 0; g < Q_W; g++)
    begin : g_stage
        logic            valid_in;
        dv_stage_t       in_s;
        dv_stage_t       stage_next;
        logic [DR_W-1:0] cur [3];

        if (g == 0)
        begin : g_first
            assign valid_in  = dreq_valid;
            assign in_s.pick = dreq.pick;
            assign in_s.root = dreq.root;
            assign in_s.den  = dreq.den;
            assign in_s.neg  = dreq.neg;
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign in_s.rem[i] = DR_W'(dreq.dvd[i][DVD_W-1:Q_W]);
                assign in_s.dv[i]  = dreq.dvd[i][Q_W-1:0];
                assign in_s.q[i]   = '0;
            end
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[g-1];
            assign in_s     = stage_reg[g-1];
        end

        always_comb
        begin
            stage_next.pick = in_s.pick;
            stage_next.root = in_s.root;
            stage_next.den  = in_s.den;
            stage_next.neg  = in_s.neg;
            for (int i = 0; i < 3; i++)
            begin
                cur[i]           = {in_s.rem[i][DR_W-2:0], in_s.dv[i][Q_W-1]};
                stage_next.dv[i] = in_s.dv[i] << 1;
                if (cur[i] >= DR_W'(in_s.den))
                begin
                    stage_next.rem[i] = cur[i] - DR_W'(in_s.den);
                    stage_next.q[i]   = {in_s.q[i][Q_W-2:0], 1'b1};
                end
                else
                begin
                    stage_next.rem[i] = cur[i];
                    stage_next.q[i]   = {in_s.q[i][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[g] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stage_reg[g] <= stage_next;
            end
        end
    end

    function automatic elem_t sat_comp(input logic [Q_W-1:0] q, input logic neg);
        logic signed [Q_W:0] v;
        v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (v > SAT_HI)
        begin
            v = SAT_HI;
        end
        if (v < SAT_LO)
        begin
            v = SAT_LO;
        end
        return v[DW-1:0];
    endfunction

    dv_stage_t last;
    elem_t     c0;
    elem_t     c1;
    elem_t     c2;
    elem_t     p;
    logic      res_valid_reg;
    quat_t     res_reg;
    quat_t     res_next;

    assign last = stage_reg[Q_W-1];

    always_comb
    begin
        c0 = sat_comp(last.q[0], last.neg[0]);
        c1 = sat_comp(last.q[1], last.neg[1]);
        c2 = sat_comp(last.q[2], last.neg[2]);
        p  = DW'(last.root);
        unique case (last.pick)
            PICK_W:  res_next = '{w: p,  x: c0, y: c1, z: c2};
            PICK_X:  res_next = '{w: c0, x: p,  y: c1, z: c2};
            PICK_Y:  res_next = '{w: c0, x: c1, y: p,  z: c2};
            default: res_next = '{w: c0, x: c1, y: c2, z: p};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= valid_reg[Q_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ rtl/core/rmq_checker.sv @@
// Port-level assertions for the converter, bound to the top level.
module rmq_checker import rmq_pkg::*; (
    input logic  clk,
    input logic  rst_n,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input elem_t w,
    input elem_t x,
    input elem_t y,
    input elem_t z
);

    localparam elem_t P_MIN = DW'(1 << (FB - 1));

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output beat shown during reset");

    a_ready_rule: assert property (@(posedge clk) in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow the output stall");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(w) && $stable(x)
                                    && $stable(y) && $stable(z))
        else $error("stalled output beat changed");

    // The picked component is a root of at least one half.
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (w >= P_MIN) || (x >= P_MIN) || (y >= P_MIN) || (z >= P_MIN))
        else $error("no component carries the root");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (mat.ready),
    .out_valid (quat.valid),
    .out_ready (quat.ready),
    .w         (quat.quat_w),
    .x         (quat.quat_x),
    .y         (quat.quat_y),
    .z         (quat.quat_z)
);
